// ===== rtl/rsch_pkg.sv =====
// Shared constants and types of the ray against sphere closest-hit pipeline.
package rsch_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int DIST_W      = 31;
    localparam int COLOUR_W    = 24;
    localparam int RSQ_W       = 62;
    localparam int BEST_W      = DIST_W + COLOUR_W;
    localparam int MUL_LIMB    = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int OUT_TDATA_W = ((2 + 2 * DIST_W + COLOUR_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] EPS_RESET = DIST_W'(655);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X,
        CFG_CENTRE_Y,
        CFG_CENTRE_Z,
        CFG_RADIUS_SQ,
        CFG_COLOUR,
        CFG_MIN_DIST
    } cfg_idx_t;

endpackage

// ===== rtl/ray_sphere_closest_hit_top.sv =====
// Throughput: one ray per cycle unless the output is held; the square-root and divider pipelines set the depth.
// The whole pipeline holds while a finished result waits and m_tready is low.
// Reset clears all valid bits and loads the register defaults (min_distance 655).
// Top level of the ray against sphere closest-hit pipeline.
module ray_sphere_closest_hit_top
    import rsch_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_distance, best_colour
    input  logic [((6*COORD_WIDTH+BEST_W+7)/8)*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, root_distance, new_best_distance, new_best_colour, replaced
    output logic [OUT_TDATA_W-1:0]        m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int TW  = W + 1;
    localparam int AW  = 2 * W;
    localparam int HW  = 2 * W + 2;
    localparam int PW1 = 2 * TW;
    localparam int CW  = ((2 * W + 2 > RSQ_W) ? 2 * W + 2 : RSQ_W) + 1;
    localparam int OW2 = CW;
    localparam int DW  = 2 * OW2 + 1;
    localparam int RW  = (DW - 1 + 1) / 2;
    localparam int NW  = OW2 + 2;
    localparam int SQ_SIDE_W = 1 + (HW + 1) + AW + BEST_W;

    logic en;

    // Configuration registers.
    logic [W-1:0]        cx_reg, cy_reg, cz_reg;
    logic [RSQ_W-1:0]    rsq_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [DIST_W-1:0]   min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            rsq_reg    <= '0;
            colour_reg <= '0;
            min_reg    <= EPS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CENTRE_X:  cx_reg     <= cfg_data[W-1:0];
                CFG_CENTRE_Y:  cy_reg     <= cfg_data[W-1:0];
                CFG_CENTRE_Z:  cz_reg     <= cfg_data[W-1:0];
                CFG_RADIUS_SQ: rsq_reg    <= cfg_data[RSQ_W-1:0];
                CFG_COLOUR:    colour_reg <= cfg_data[COLOUR_W-1:0];
                CFG_MIN_DIST:  min_reg    <= cfg_data[DIST_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Output stage valid; the whole pipeline advances unless it is held.
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Stage A: offsets from the centre.
    logic [W-1:0]         o_in [3];
    logic [W-1:0]         d_in [3];
    logic [W-1:0]         cen [3];
    logic signed [TW-1:0] d_reg [3];
    logic signed [TW-1:0] t_reg [3];
    logic [BEST_W-1:0]    best_a_reg;
    logic                 va_reg;

    always_comb
    begin
        cen[0] = cx_reg;
        cen[1] = cy_reg;
        cen[2] = cz_reg;
        for (int k = 0; k < 3; k++)
        begin
            o_in[k] = s_tdata[k*W +: W];
            d_in[k] = s_tdata[(3+k)*W +: W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= {d_in[k][W-1], d_in[k]};
                t_reg[k] <= $signed({o_in[k][W-1], o_in[k]}) - $signed({cen[k][W-1], cen[k]});
            end
            best_a_reg <= s_tdata[6*W +: BEST_W];
        end
    end

    // Dot products: d.d, d.T, T.T per axis.
    logic signed [TW-1:0]  m1_a [9];
    logic signed [TW-1:0]  m1_b [9];
    logic signed [PW1-1:0] m1_p [9];
    logic [BEST_W-1:0]     m1_side;
    logic                  m1_valid;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m1_a[k]   = d_reg[k];
            m1_b[k]   = d_reg[k];
            m1_a[3+k] = d_reg[k];
            m1_b[3+k] = t_reg[k];
            m1_a[6+k] = t_reg[k];
            m1_b[6+k] = t_reg[k];
        end
    end

    rsch_mul #(.OW(TW), .LANES(9), .SIDE_W(BEST_W)) u_mul_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (va_reg),
        .a         (m1_a),
        .b         (m1_b),
        .side_in   (best_a_reg),
        .out_valid (m1_valid),
        .p         (m1_p),
        .side_out  (m1_side)
    );

    // Stage B: a, h and c.
    logic [PW1-1:0]       asum;
    logic [AW-1:0]        a_reg;
    logic signed [HW-1:0] h_reg;
    logic signed [CW-1:0] c_reg;
    logic [AW-1:0]        a_next;
    logic signed [HW-1:0] h_next;
    logic signed [CW-1:0] c_next;
    logic [BEST_W-1:0]    best_b_reg;
    logic                 vb_reg;

    always_comb
    begin
        asum   = m1_p[0] + m1_p[1] + m1_p[2];
        a_next = asum[AW-1:0];
        h_next = m1_p[3] + m1_p[4] + m1_p[5];
        c_next = $signed({{(CW-PW1){m1_p[6][PW1-1]}}, m1_p[6]})
               + $signed({{(CW-PW1){m1_p[7][PW1-1]}}, m1_p[7]})
               + $signed({{(CW-PW1){m1_p[8][PW1-1]}}, m1_p[8]})
               - $signed({{(CW-RSQ_W){1'b0}}, rsq_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_next;
            h_reg      <= h_next;
            c_reg      <= c_next;
            best_b_reg <= m1_side;
        end
    end

    // Discriminant products h*h and a*c.
    logic signed [OW2-1:0]   m2_a [2];
    logic signed [OW2-1:0]   m2_b [2];
    logic signed [2*OW2-1:0] m2_p [2];
    logic [AW+HW+BEST_W-1:0] m2_side;
    logic                    m2_valid;

    always_comb
    begin
        m2_a[0] = {{(OW2-HW){h_reg[HW-1]}}, h_reg};
        m2_b[0] = {{(OW2-HW){h_reg[HW-1]}}, h_reg};
        m2_a[1] = {{(OW2-AW){1'b0}}, a_reg};
        m2_b[1] = c_reg;
    end

    rsch_mul #(.OW(OW2), .LANES(2), .SIDE_W(AW+HW+BEST_W)) u_mul_disc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .a         (m2_a),
        .b         (m2_b),
        .side_in   ({a_reg, h_reg, best_b_reg}),
        .out_valid (m2_valid),
        .p         (m2_p),
        .side_out  (m2_side)
    );

    // Stage C: discriminant sign, magnitude for the root and -h.
    logic signed [DW-1:0] disc;
    logic [AW-1:0]        a_c;
    logic [HW-1:0]        h_c;
    logic [BEST_W-1:0]    best_c;
    logic                 ok_c_reg;
    logic [DW-2:0]        dmag_reg;
    logic signed [HW:0]   nh_c_reg;
    logic [AW-1:0]        a_c_reg;
    logic [BEST_W-1:0]    best_c_reg;
    logic                 vc_reg;

    always_comb
    begin
        {a_c, h_c, best_c} = m2_side;
        disc = $signed({m2_p[0][2*OW2-1], m2_p[0]}) - $signed({m2_p[1][2*OW2-1], m2_p[1]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A zero direction or a negative discriminant can never hit.
            ok_c_reg   <= (a_c != '0) && !disc[DW-1];
            dmag_reg   <= disc[DW-1] ? '0 : disc[DW-2:0];
            nh_c_reg   <= $signed({(HW+1){1'b0}}) - $signed({h_c[HW-1], h_c});
            a_c_reg    <= a_c;
            best_c_reg <= best_c;
        end
    end

    logic [RW-1:0]        sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic                 sq_valid;

    rsch_sqrt #(.DIN_W(DW-1), .SIDE_W(SQ_SIDE_W)) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .d_in      (dmag_reg),
        .side_in   ({ok_c_reg, nh_c_reg, a_c_reg, best_c_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // Stage E: numerators of the near and far roots.
    logic                 ok_s;
    logic [HW:0]          nh_s;
    logic [AW-1:0]        a_s;
    logic [BEST_W-1:0]    best_s;
    logic signed [NW-1:0] nhx;
    logic signed [NW-1:0] sx;
    logic signed [NW-1:0] num_reg [2];
    logic [AW-1:0]        a_e_reg;
    logic                 ok_e_reg;
    logic [BEST_W-1:0]    best_e_reg;
    logic                 ve_reg;

    always_comb
    begin
        {ok_s, nh_s, a_s, best_s} = sq_side;
        nhx = {{(NW-HW-1){nh_s[HW]}}, nh_s};
        sx  = {{(NW-RW){1'b0}}, sq_root};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= nhx - sx;
            num_reg[1] <= nhx + sx;
            a_e_reg    <= a_s;
            ok_e_reg   <= ok_s;
            best_e_reg <= best_s;
        end
    end

    logic [DIST_W-1:0] dv_dist [2];
    logic              dv_neg [2];
    logic [BEST_W:0]   dv_side;
    logic              dv_valid;

    rsch_div #(.NW(NW), .AW(AW), .FB(FRAC_BITS), .LANES(2), .SIDE_W(BEST_W+1)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ve_reg),
        .n         (num_reg),
        .a         (a_e_reg),
        .side_in   ({ok_e_reg, best_e_reg}),
        .out_valid (dv_valid),
        .quo       (dv_dist),
        .neg       (dv_neg),
        .side_out  (dv_side)
    );

    // Output stage: pick the first root not below epsilon and update the best hit.
    logic                ok_d;
    logic [DIST_W-1:0]   best_d;
    logic [COLOUR_W-1:0] bcol_d;
    logic                near_ok, far_ok, hit_next, rep_next;
    logic [DIST_W-1:0]   root_next;
    logic                hit_reg, rep_reg;
    logic [DIST_W-1:0]   root_reg, nbd_reg;
    logic [COLOUR_W-1:0] nbc_reg;

    always_comb
    begin
        {ok_d, bcol_d, best_d} = dv_side;
        near_ok  = !dv_neg[0] && (dv_dist[0] >= min_reg);
        far_ok   = !dv_neg[1] && (dv_dist[1] >= min_reg);
        hit_next = ok_d && (near_ok || far_ok);
        priority if (!hit_next)
            root_next = '0;
        else if (near_ok)
            root_next = dv_dist[0];
        else
            root_next = dv_dist[1];
        rep_next = hit_next && (root_next < best_d);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            root_reg <= root_next;
            rep_reg  <= rep_next;
            nbd_reg  <= rep_next ? root_next : best_d;
            nbc_reg  <= rep_next ? colour_reg : bcol_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg        <= s_tvalid;
            vb_reg        <= m1_valid;
            vc_reg        <= m2_valid;
            ve_reg        <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({rep_reg, nbc_reg, nbd_reg, root_reg, hit_reg});

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> root_reg == '0)
        else $error("miss with nonzero root distance");

    a_replace_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rep_reg |-> hit_reg && (nbd_reg == root_reg) && (nbc_reg == colour_reg))
        else $error("replacement without matching hit");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while the pipeline is held");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(root_reg) && $stable(nbd_reg))
        else $error("held result changed");

endmodule

// ===== rtl/rsch_mul.sv =====
// Pipelined signed multiplier lanes built from 32x32 limb products.
module rsch_mul
    import rsch_pkg::*;
#(
    parameter int OW     = 33,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [OW-1:0]     a [LANES],
    input  logic signed [OW-1:0]     b [LANES],
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic signed [2*OW-1:0]   p [LANES],
    output logic [SIDE_W-1:0]        side_out
);

    localparam int NL   = (OW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int PADW = NL * MUL_LIMB;
    localparam int PPW  = 2 * MUL_LIMB;

    logic [OW-1:0]          ua [LANES];
    logic [OW-1:0]          ub [LANES];
    logic [OW-1:0]          abs_a [LANES];
    logic [OW-1:0]          abs_b [LANES];
    logic [2*PADW-1:0]      acc [LANES];

    logic [PADW-1:0]        ma_reg [LANES];
    logic [PADW-1:0]        mb_reg [LANES];
    logic [PADW-1:0]        ma_next [LANES];
    logic [PADW-1:0]        mb_next [LANES];
    logic                   neg1_reg [LANES];
    logic                   neg2_reg [LANES];
    logic                   neg3_reg [LANES];
    logic [PPW-1:0]         pp_reg [LANES][NL*NL];
    logic [PPW-1:0]         pp_next [LANES][NL*NL];
    logic [2*OW-1:0]        sum_reg [LANES];
    logic [2*OW-1:0]        sum_next [LANES];
    logic signed [2*OW-1:0] p_reg [LANES];
    logic signed [2*OW-1:0] p_next [LANES];
    logic [3:0]             v_reg;
    logic [SIDE_W-1:0]      side_reg [4];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ua[l]    = a[l];
            ub[l]    = b[l];
            abs_a[l] = ua[l][OW-1] ? (~ua[l] + 1'b1) : ua[l];
            abs_b[l] = ub[l][OW-1] ? (~ub[l] + 1'b1) : ub[l];
            ma_next[l] = PADW'(abs_a[l]);
            mb_next[l] = PADW'(abs_b[l]);
            for (int i = 0; i < NL; i++)
            begin
                for (int j = 0; j < NL; j++)
                begin
                    pp_next[l][i*NL+j] = ma_reg[l][i*MUL_LIMB +: MUL_LIMB]
                                       * mb_reg[l][j*MUL_LIMB +: MUL_LIMB];
                end
            end
            acc[l] = '0;
            for (int i = 0; i < NL; i++)
            begin
                for (int j = 0; j < NL; j++)
                begin
                    acc[l] = acc[l]
                           + ((2*PADW)'(pp_reg[l][i*NL+j]) << (MUL_LIMB * (i + j)));
                end
            end
            sum_next[l] = acc[l][2*OW-1:0];
            p_next[l]   = neg3_reg[l] ? $signed(~sum_reg[l] + 1'b1) : $signed(sum_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
            for (int l = 0; l < LANES; l++)
            begin
                ma_reg[l]   <= ma_next[l];
                mb_reg[l]   <= mb_next[l];
                neg1_reg[l] <= a[l][OW-1] ^ b[l][OW-1];
                neg2_reg[l] <= neg1_reg[l];
                neg3_reg[l] <= neg2_reg[l];
                pp_reg[l]   <= pp_next[l];
                sum_reg[l]  <= sum_next[l];
                p_reg[l]    <= p_next[l];
            end
        end
    end

    assign out_valid = v_reg[3];
    assign side_out  = side_reg[3];
    assign p         = p_reg;

endmodule

// ===== rtl/rsch_sqrt.sv =====
// Pipelined restoring integer square root, one root bit per stage.
module rsch_sqrt
    import rsch_pkg::*;
#(
    parameter int DIN_W  = 134,
    parameter int SIDE_W = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [DIN_W-1:0]              d_in,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [(DIN_W+1)/2-1:0]        root,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int RW = (DIN_W + 1) / 2;
    localparam int XW = 2 * RW;

    logic [RW+1:0]     remsh [RW];
    logic [RW+1:0]     trial [RW];

    logic [XW-1:0]     x_reg [0:RW];
    logic [XW-1:0]     x_next [0:RW];
    logic [RW+1:0]     rem_reg [0:RW];
    logic [RW+1:0]     rem_next [0:RW];
    logic [RW-1:0]     root_reg [0:RW];
    logic [RW-1:0]     root_next [0:RW];
    logic              v_reg [0:RW];
    logic [SIDE_W-1:0] side_reg [0:RW];

    always_comb
    begin
        x_next[0]    = XW'(d_in);
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int k = 0; k < RW; k++)
        begin
            // Bring down the next bit pair and try the digit one.
            remsh[k]    = {rem_reg[k][RW-1:0], x_reg[k][XW-1 -: 2]};
            trial[k]    = {root_reg[k], 2'b01};
            x_next[k+1] = {x_reg[k][XW-3:0], 2'b00};
            if (remsh[k] >= trial[k])
            begin
                rem_next[k+1]  = remsh[k] - trial[k];
                root_next[k+1] = {root_reg[k][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1]  = remsh[k];
                root_next[k+1] = {root_reg[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < RW; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 0; k < RW; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
            for (int k = 0; k <= RW; k++)
            begin
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign root      = root_reg[RW];
    assign side_out  = side_reg[RW];

endmodule

// ===== rtl/rsch_div.sv =====
// Pipelined restoring divider lanes giving a saturated distance quotient.
module rsch_div
    import rsch_pkg::*;
#(
    parameter int NW     = 69,
    parameter int AW     = 64,
    parameter int FB     = 16,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [NW-1:0]     n [LANES],
    input  logic [AW-1:0]            a,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic [DIST_W-1:0]        quo [LANES],
    output logic                     neg [LANES],
    output logic [SIDE_W-1:0]        side_out
);

    localparam int QB   = DIST_W;
    localparam int XW   = NW + FB;
    localparam int HIW  = XW - QB;
    localparam int CMPW = (HIW > AW) ? HIW : AW;

    logic [XW-1:0]     xs [LANES];
    logic [HIW-1:0]    hi [LANES];
    logic [AW:0]       remsh [LANES][QB];

    logic [AW-1:0]     rem_reg [LANES][0:QB];
    logic [AW-1:0]     rem_next [LANES][0:QB];
    logic [QB-1:0]     xl_reg [LANES][0:QB];
    logic [QB-1:0]     xl_next [LANES][0:QB];
    logic [QB-1:0]     q_reg [LANES][0:QB];
    logic [QB-1:0]     q_next [LANES][0:QB];
    logic              neg_reg [LANES][0:QB];
    logic              ovf_reg [LANES][0:QB];
    logic              ovf_next [LANES];
    logic [AW-1:0]     a_reg [0:QB];
    logic              v_reg [0:QB];
    logic [SIDE_W-1:0] side_reg [0:QB];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            xs[l] = {n[l], {FB{1'b0}}};
            hi[l] = xs[l][XW-1:QB];
            // The quotient overflows the distance range when the high part reaches a.
            ovf_next[l]    = CMPW'(hi[l]) >= CMPW'(a);
            rem_next[l][0] = AW'(hi[l]);
            xl_next[l][0]  = xs[l][QB-1:0];
            q_next[l][0]   = '0;
            for (int k = 0; k < QB; k++)
            begin
                remsh[l][k]     = {rem_reg[l][k], xl_reg[l][k][QB-1]};
                xl_next[l][k+1] = {xl_reg[l][k][QB-2:0], 1'b0};
                if (remsh[l][k] >= {1'b0, a_reg[k]})
                begin
                    rem_next[l][k+1] = AW'(remsh[l][k] - {1'b0, a_reg[k]});
                    q_next[l][k+1]   = {q_reg[l][k][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l][k+1] = AW'(remsh[l][k]);
                    q_next[l][k+1]   = {q_reg[l][k][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < QB; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]    <= a;
            side_reg[0] <= side_in;
            for (int k = 0; k < QB; k++)
            begin
                a_reg[k+1]    <= a_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[l][0] <= n[l][NW-1];
                ovf_reg[l][0] <= ovf_next[l];
                for (int k = 0; k < QB; k++)
                begin
                    neg_reg[l][k+1] <= neg_reg[l][k];
                    ovf_reg[l][k+1] <= ovf_reg[l][k];
                end
                for (int k = 0; k <= QB; k++)
                begin
                    rem_reg[l][k] <= rem_next[l][k];
                    xl_reg[l][k]  <= xl_next[l][k];
                    q_reg[l][k]   <= q_next[l][k];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = ovf_reg[l][QB] ? DIST_MAX : q_reg[l][QB];
            neg[l] = neg_reg[l][QB];
        end
    end

    assign out_valid = v_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the ray against sphere closest-hit pipeline.
module tb_top;
    import rsch_pkg::*;

    typedef logic signed [255:0] wide_t;

    // Packed from the most significant field down, so origin_x lands in the lowest bits.
    typedef struct packed {
        logic [COLOUR_W-1:0]  colour;
        logic [DIST_W-1:0]    best;
        logic signed [31:0]   dz, dy, dx, oz, oy, ox;
    } ray_t;

    typedef struct packed {
        logic                 replaced;
        logic [COLOUR_W-1:0]  colour;
        logic [DIST_W-1:0]    new_best;
        logic [DIST_W-1:0]    root;
        logic                 hit;
    } hit_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [31:0]          ONE        = 32'h0001_0000;
    localparam logic [63:0]          RSQ_ONE    = 64'h1_0000_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [247:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the sphere registers.
    logic signed [31:0]    sph_cx, sph_cy, sph_cz;
    logic [RSQ_W-1:0]      sph_rsq;
    logic [COLOUR_W-1:0]   sph_colour;
    logic [DIST_W-1:0]     sph_eps;

    hit_t                  pending_hits[$];
    int                    errors;
    bit                    burst;

    ray_sphere_closest_hit_top dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic wide_t isqrt(wide_t x);
        wide_t r, trial;
        r = '0;
        for (int i = 127; i >= 0; i--)
        begin
            trial = r | (wide_t'(1) << i);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    // Root distance floor(num * 2^16 / a), saturated; -1 when num is negative or the distance is below epsilon.
    function automatic longint root_of(wide_t num, wide_t a);
        wide_t q;
        longint t;
        if (num < 0)
            return -1;
        q = $unsigned(num <<< 16) / $unsigned(a);
        t = (q >= wide_t'(DIST_MAX)) ? longint'(DIST_MAX) : longint'(q);
        return (t >= longint'(sph_eps)) ? t : -1;
    endfunction

    function automatic hit_t closest_hit(ray_t r);
        wide_t a, h, c, t, disc, s;
        wide_t o[3], d[3], ce[3];
        longint root;
        hit_t res;
        o  = '{wide_t'(r.ox), wide_t'(r.oy), wide_t'(r.oz)};
        d  = '{wide_t'(r.dx), wide_t'(r.dy), wide_t'(r.dz)};
        ce = '{wide_t'(sph_cx), wide_t'(sph_cy), wide_t'(sph_cz)};
        a = '0;
        h = '0;
        c = '0;
        for (int k = 0; k < 3; k++)
        begin
            t = o[k] - ce[k];
            a += d[k] * d[k];
            h += d[k] * t;
            c += t * t;
        end
        c -= wide_t'({194'b0, sph_rsq});
        disc = h * h - a * c;
        root = -1;
        if (a != 0 && disc >= 0)
        begin
            s = isqrt(disc);
            root = root_of(-h - s, a);
            if (root < 0)
                root = root_of(-h + s, a);
        end
        res.hit      = (root >= 0);
        res.root     = res.hit ? DIST_W'(root) : '0;
        res.replaced = res.hit && (res.root < r.best);
        res.new_best = res.replaced ? res.root : r.best;
        res.colour   = res.replaced ? sph_colour : r.colour;
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTRE_X:  sph_cx = value[31:0];
            CFG_CENTRE_Y:  sph_cy = value[31:0];
            CFG_CENTRE_Z:  sph_cz = value[31:0];
            CFG_RADIUS_SQ: sph_rsq = value[RSQ_W-1:0];
            CFG_COLOUR:    sph_colour = value[COLOUR_W-1:0];
            CFG_MIN_DIST:  sph_eps = value[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // A typed expectation, when given, stands in place of the predictor's.
    task automatic send_ray(ray_t r, bit typed = 1'b0, hit_t typed_exp = '0);
        int gap;
        gap = burst ? 0 : $urandom_range(15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r};
        do
            @(posedge clk);
        while (!s_tready);
        pending_hits.insert(pending_hits.size(), typed ? typed_exp : closest_hit(r));
    endtask

    function automatic ray_t random_ray();
        ray_t r;
        r.colour = COLOUR_W'($urandom);
        r.best   = ($urandom_range(3) == 0) ? DIST_MAX : DIST_W'($urandom_range(ONE * 12));
        if ($urandom_range(9) == 0)
        begin
            {r.ox, r.oy, r.oz, r.dx, r.dy, r.dz} = {$urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom};
            r.best = DIST_W'($urandom);
        end
        else
        begin
            // Aim roughly at the centre from a nearby origin so that most rays hit.
            r.ox = sph_cx + $signed($urandom_range(ONE * 16)) - $signed(ONE * 8);
            r.oy = sph_cy + $signed($urandom_range(ONE * 16)) - $signed(ONE * 8);
            r.oz = sph_cz + $signed($urandom_range(ONE * 16)) - $signed(ONE * 8);
            r.dx = (sph_cx - r.ox) + $signed($urandom_range(ONE * 4)) - $signed(ONE * 2);
            r.dy = (sph_cy - r.oy) + $signed($urandom_range(ONE * 4)) - $signed(ONE * 2);
            r.dz = (sph_cz - r.oz) + $signed($urandom_range(ONE * 4)) - $signed(ONE * 2);
            if ($urandom_range(3) == 0)
                r.dx = -r.dx;
        end
        return r;
    endfunction

    function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                int best, int col);
        ray_t r;
        r = '{colour: COLOUR_W'(col), best: DIST_W'(best), dz: dz, dy: dy, dx: dx,
              oz: oz, oy: oy, ox: ox};
        return r;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        hit_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_hits.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                    errors++;
                end
                if (got.root !== want.root)
                begin
                    $display("%0t: root_distance expected %0d actual %0d",
                             $time, want.root, got.root);
                    errors++;
                end
                if (got.new_best !== want.new_best)
                begin
                    $display("%0t: new_best_distance expected %0d actual %0d",
                             $time, want.new_best, got.new_best);
                    errors++;
                end
                if (got.colour !== want.colour)
                begin
                    $display("%0t: new_best_colour expected %h actual %h",
                             $time, want.colour, got.colour);
                    errors++;
                end
                if (got.replaced !== want.replaced)
                begin
                    $display("%0t: replaced expected %0d actual %0d",
                             $time, want.replaced, got.replaced);
                    errors++;
                end
            end
        end
    end

    // Output back-pressure: a random stall ahead of each result transaction, none during bursts.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst ? 0 : $urandom_range(15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        ray_t   rows[$];
        bit     typed[$];
        hit_t   typed_exp[$];
        hit_t   no_hit;
        ray_t   r;
        errors    = 0;
        burst     = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CENTRE_X;
        cfg_data  = '0;
        sph_cx = 0;
        sph_cy = 0;
        sph_cz = 0;
        sph_rsq = '0;
        sph_colour = '0;
        sph_eps = EPS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: a point sphere at the origin.
        r = mk(0, 0, 0, 0, 0, 0, DIST_MAX, 24'h123456);
        no_hit = '{replaced: 0, colour: 24'h123456, new_best: DIST_MAX, root: 0, hit: 0};
        send_ray(r, 1'b1, no_hit);
        send_ray(mk(-ONE, 0, 0, ONE, 0, 0, DIST_MAX, 24'hABCDEF));

        write_reg(CFG_CENTRE_Z, 64'(5 * ONE));
        write_reg(CFG_RADIUS_SQ, RSQ_ONE);
        write_reg(CFG_COLOUR, 64'hFF8000);
        write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);

        // Zero direction and a clean miss, then ordinary hits and the edge cases.
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, 0, 100, 24'h111111));
        typed.insert(typed.size(), 1'b1);
        typed_exp.insert(typed_exp.size(),
                         '{replaced: 0, colour: 24'h111111, new_best: 100, root: 0, hit: 0});
        rows.insert(rows.size(), mk(0, 0, 0, ONE, 0, 0, DIST_MAX, 24'hFFFFFF));
        typed.insert(typed.size(), 1'b1);
        typed_exp.insert(typed_exp.size(),
                         '{replaced: 0, colour: 24'hFFFFFF, new_best: DIST_MAX,
                           root: 0, hit: 0});
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, ONE, DIST_MAX, 24'h000000));
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, ONE, 4 * ONE, 24'h00FF00));
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, ONE, 4 * ONE + 1, 24'h00FF00));
        rows.insert(rows.size(), mk(0, 0, 5 * ONE, 0, 0, ONE, DIST_MAX, 24'h0000FF));
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, -ONE, DIST_MAX, 24'h0000FF));
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, 1, DIST_MAX, 24'h777777));
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0, 1, DIST_MAX - 1, 24'h777777));
        rows.insert(rows.size(), mk(0, 0, 4 * ONE, 0, 0, ONE, 0, 24'h000000));
        rows.insert(rows.size(), mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, DIST_MAX, 24'hFFFFFF));
        rows.insert(rows.size(), mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 24'h000000));
        rows.insert(rows.size(), mk(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0,
                    32'h7FFF_FFFF, DIST_MAX, 24'hA5A5A5));
        for (int i = 0; i < rows.size(); i++)
        begin
            if (i < typed.size())
                send_ray(rows[i], typed[i], typed_exp[i]);
            else
                send_ray(rows[i]);
        end

        // A root of exactly zero counts once epsilon is zero.
        write_reg(CFG_MIN_DIST, 64'd0);
        send_ray(mk(0, 0, 4 * ONE, 0, 0, ONE, DIST_MAX, 24'h123123));
        send_ray(mk(0, 0, 6 * ONE, 0, 0, ONE, DIST_MAX, 24'h123123));
        write_reg(CFG_MIN_DIST, 64'(DIST_MAX));
        send_ray(mk(0, 0, 0, 0, 0, 1, DIST_MAX - 1, 24'h321321));
        send_ray(mk(0, 0, 0, 0, 0, ONE, DIST_MAX, 24'h321321));

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_MIN_DIST, 64'(EPS_RESET));
                    write_reg(CFG_RADIUS_SQ, 64'(4) << 32);
                end
                1:
                begin
                    write_reg(CFG_CENTRE_X, 64'h7FFF_0000);
                    write_reg(CFG_CENTRE_Y, 64'h8000_0000);
                    write_reg(CFG_CENTRE_Z, 64'hFFFF_FFFF_0001_0000);
                    write_reg(CFG_RADIUS_SQ, 64'h3FFF_FFFF_FFFF_FFFF);
                    write_reg(CFG_COLOUR, 64'hFFFFFF);
                    write_reg(CFG_MIN_DIST, 64'd0);
                end
                2:
                begin
                    write_reg(CFG_CENTRE_X, 64'($signed($urandom_range(ONE * 64)) - ONE * 32));
                    write_reg(CFG_CENTRE_Y, 64'($signed($urandom_range(ONE * 64)) - ONE * 32));
                    write_reg(CFG_CENTRE_Z, 64'($signed($urandom_range(ONE * 64)) - ONE * 32));
                    write_reg(CFG_RADIUS_SQ, 64'($urandom_range(25)) << 32 | 64'($urandom));
                    write_reg(CFG_COLOUR, 64'($urandom));
                    write_reg(CFG_MIN_DIST, 64'($urandom_range(ONE)));
                end
                3:
                begin
                    write_reg(CFG_CENTRE_X, 64'h8000_0000);
                    write_reg(CFG_CENTRE_Y, 64'h7FFF_FFFF);
                    write_reg(CFG_CENTRE_Z, 64'd0);
                    write_reg(CFG_RADIUS_SQ, 64'd0);
                    write_reg(CFG_COLOUR, 64'd0);
                    write_reg(CFG_MIN_DIST, 64'(ONE * 2));
                end
                default:
                begin
                    write_reg(CFG_CENTRE_X, 64'(ONE * 3));
                    write_reg(CFG_CENTRE_Y, 64'(-ONE * 2));
                    write_reg(CFG_CENTRE_Z, 64'(ONE * 7));
                    write_reg(CFG_RADIUS_SQ, 64'(9) << 32);
                    write_reg(CFG_COLOUR, 64'h5A5A5A);
                    write_reg(CFG_MIN_DIST, 64'(EPS_RESET));
                end
            endcase
            for (int n = 0; n < 185; n++)
            begin
                if (n % 60 == 0)
                    burst = ($urandom_range(2) == 0);
                // Let the pipeline run completely dry once, midway through phase 2.
                if (phase == 2 && n == 90)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_ray(random_ray());
            end
        end
        s_tvalid <= 1'b0;
        burst = 1'b0;

        wait_drained();
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rsch_pkg.sv
rtl/rsch_mul.sv
rtl/rsch_sqrt.sv
rtl/rsch_div.sv
rtl/ray_sphere_closest_hit_top.sv
test/tb_top.sv
